// ===== rtl/cdec_pkg.sv =====
// Shared types and constants for the chunked transfer decoder.
// Used by the step logic, the top level and the checker.
package cdec_pkg;

  // Default width of the chunk size counter.
  localparam int unsigned SIZE_WIDTH_DEF = 32;

  // Delimiter and hex digit characters.
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // Parser phase codes; unused codes fall into a default arm.
  typedef enum logic [3:0] {
    PH_SIZE       = 4'd0,
    PH_EXT        = 4'd1,
    PH_SIZE_LF    = 4'd2,
    PH_DATA       = 4'd3,
    PH_DATA_CR    = 4'd4,
    PH_DATA_LF    = 4'd5,
    PH_TRAIL      = 4'd6,
    PH_TRAIL_SKIP = 4'd7,
    PH_TRAIL_LF   = 4'd8,
    PH_END_LF     = 4'd9,
    PH_DONE       = 4'd10
  } cdec_phase_t;

  // Per-word status codes.
  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } cdec_status_t;

  // Control part of the parser state.
  typedef struct packed {
    cdec_phase_t phase;
    logic        have_digit;
    logic        err;
  } cdec_ctl_t;

  // One result word.
  typedef struct packed {
    logic         payload_valid;
    logic [7:0]   payload_byte;
    cdec_status_t status;
  } cdec_res_t;

endpackage

// ===== rtl/cdec_if.sv =====
// Valid/ready channel interfaces for the chunked transfer decoder.
// Input words carry a body byte and a start flag; result words carry payload and status.
interface cdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_message;

  modport source (output valid, output data_byte, output start_message, input ready);
  modport sink   (input valid, input data_byte, input start_message, output ready);
endinterface

interface cdec_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [1:0] status;

  modport source (output valid, output payload_valid, output payload_byte,
                  output status, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input status, output ready);
endinterface

// ===== rtl/chunked_transfer_decoder_core.sv =====
// Top level of the chunked transfer decoder: input register, step logic, result register.
// Depends on cdec_pkg, cdec_if (channel interfaces) and cdec_step.
//
//   Channel   Direction  Word contents
//   in_ch     sink       data_byte, start_message
//   out_ch    source     payload_valid, payload_byte, status
//
// Every byte yields exactly one result word; one word is accepted per cycle unless stalled.
// A byte passes through the input register, then the step logic into the result register.
// The parser state updates in the same cycle a byte moves into the result register.
// rst_n is synchronous and active low; it clears the parser state and both valid flags.
// If out_ch stalls the result register holds; in_ch.ready falls when the input register fills.
module chunked_transfer_decoder_core #(
  parameter int unsigned SIZE_WIDTH = cdec_pkg::SIZE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cdec_in_if.sink     in_ch,
  cdec_out_if.source  out_ch
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic                  in_start_r;
  cdec_pkg::cdec_ctl_t   ctl_r;
  cdec_pkg::cdec_ctl_t   ctl_nxt;
  logic [SIZE_WIDTH-1:0] rem_r;
  logic [SIZE_WIDTH-1:0] rem_nxt;
  logic                  out_vld_r;
  cdec_pkg::cdec_res_t   res_r;
  cdec_pkg::cdec_res_t   res_nxt;
  logic                  advance;
  logic                  process;

  // The pipeline moves when the result register is free or being drained.
  assign advance     = !out_vld_r || out_ch.ready;
  assign process     = advance && in_vld_r;
  assign in_ch.ready = !in_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r  <= in_ch.data_byte;
      in_start_r <= in_ch.start_message;
    end
  end

  cdec_step #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_step (
    .ctl_i   (ctl_r),
    .rem_i   (rem_r),
    .byte_i  (in_byte_r),
    .start_i (in_start_r),
    .ctl_o   (ctl_nxt),
    .rem_o   (rem_nxt),
    .res_o   (res_nxt)
  );

  // Parser state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase      <= cdec_pkg::PH_SIZE;
      ctl_r.have_digit <= 1'b0;
      ctl_r.err        <= 1'b0;
      rem_r            <= '0;
      out_vld_r        <= 1'b0;
    end else begin
      if (advance) out_vld_r <= in_vld_r;
      if (process) begin
        ctl_r <= ctl_nxt;
        rem_r <= rem_nxt;
      end
    end
    if (process) res_r <= res_nxt;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.status        = res_r.status;

endmodule

// ===== rtl/cdec_step.sv =====
// Next-state and result logic of the chunked decoder for one byte.
// Depends on cdec_pkg for phase and status codes and characters.
module cdec_step #(
  parameter int unsigned SIZE_WIDTH = cdec_pkg::SIZE_WIDTH_DEF
) (
  input  cdec_pkg::cdec_ctl_t    ctl_i,
  input  logic [SIZE_WIDTH-1:0]  rem_i,
  input  logic [7:0]             byte_i,
  input  logic                   start_i,
  output cdec_pkg::cdec_ctl_t    ctl_o,
  output logic [SIZE_WIDTH-1:0]  rem_o,
  output cdec_pkg::cdec_res_t    res_o
);

  cdec_pkg::cdec_ctl_t    cur;
  logic [SIZE_WIDTH-1:0]  rem;
  logic                   is_hex;
  logic [3:0]             hex_val;
  logic                   ovf;
  logic                   pv;
  cdec_pkg::cdec_status_t st;
  logic [SIZE_WIDTH-1:0]  rem_dec;

  // Hex digit decode.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= cdec_pkg::CH_0 && byte_i <= cdec_pkg::CH_9) begin
      hex_val = 4'(byte_i - cdec_pkg::CH_0);
    end else if (byte_i >= cdec_pkg::CH_LO_A && byte_i <= cdec_pkg::CH_LO_F) begin
      hex_val = 4'(byte_i - cdec_pkg::CH_LO_A + 8'd10);
    end else if (byte_i >= cdec_pkg::CH_UP_A && byte_i <= cdec_pkg::CH_UP_F) begin
      hex_val = 4'(byte_i - cdec_pkg::CH_UP_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // A new message starts from the reset state.
  always_comb begin
    if (start_i) begin
      cur.phase      = cdec_pkg::PH_SIZE;
      cur.have_digit = 1'b0;
      cur.err        = 1'b0;
      rem            = '0;
    end else begin
      cur = ctl_i;
      rem = rem_i;
    end
  end

  // Another digit would push bits out of the top of the counter.
  assign ovf     = |rem[SIZE_WIDTH-1:SIZE_WIDTH-4];
  assign rem_dec = rem - SIZE_WIDTH'(1);

  // Phase transitions; a bad byte leaves the state alone except the error flag.
  always_comb begin
    ctl_o = cur;
    rem_o = rem;
    pv    = 1'b0;
    st    = cdec_pkg::ST_CONT;
    if (cur.err) begin
      st = cdec_pkg::ST_BAD;
    end else begin
      unique case (cur.phase)
        cdec_pkg::PH_SIZE: begin
          if (is_hex) begin
            if (ovf) begin
              st = cdec_pkg::ST_BAD;
            end else begin
              rem_o            = {rem[SIZE_WIDTH-5:0], hex_val};
              ctl_o.have_digit = 1'b1;
            end
          end else if (byte_i == cdec_pkg::CH_SEMI || byte_i == cdec_pkg::CH_CR) begin
            if (!cur.have_digit) begin
              st = cdec_pkg::ST_BAD;
            end else if (byte_i == cdec_pkg::CH_SEMI) begin
              ctl_o.phase = cdec_pkg::PH_EXT;
            end else begin
              ctl_o.phase = cdec_pkg::PH_SIZE_LF;
            end
          end else begin
            st = cdec_pkg::ST_BAD;
          end
        end
        cdec_pkg::PH_EXT: begin
          if (byte_i == cdec_pkg::CH_CR) ctl_o.phase = cdec_pkg::PH_SIZE_LF;
        end
        cdec_pkg::PH_SIZE_LF: begin
          if (byte_i != cdec_pkg::CH_LF) begin
            st = cdec_pkg::ST_BAD;
          end else if (rem == '0) begin
            ctl_o.phase = cdec_pkg::PH_TRAIL;
          end else begin
            ctl_o.phase = cdec_pkg::PH_DATA;
          end
        end
        cdec_pkg::PH_DATA: begin
          if (rem != '0) begin
            pv    = 1'b1;
            rem_o = rem_dec;
            if (rem_dec == '0) ctl_o.phase = cdec_pkg::PH_DATA_CR;
          end else if (byte_i != cdec_pkg::CH_CR) begin
            st = cdec_pkg::ST_BAD;
          end else begin
            ctl_o.phase = cdec_pkg::PH_DATA_LF;
          end
        end
        cdec_pkg::PH_DATA_CR: begin
          if (byte_i != cdec_pkg::CH_CR) begin
            st = cdec_pkg::ST_BAD;
          end else begin
            ctl_o.phase = cdec_pkg::PH_DATA_LF;
          end
        end
        cdec_pkg::PH_DATA_LF: begin
          if (byte_i != cdec_pkg::CH_LF) begin
            st = cdec_pkg::ST_BAD;
          end else begin
            ctl_o.phase      = cdec_pkg::PH_SIZE;
            ctl_o.have_digit = 1'b0;
          end
        end
        cdec_pkg::PH_TRAIL: begin
          ctl_o.phase = (byte_i == cdec_pkg::CH_CR) ? cdec_pkg::PH_END_LF
                                                    : cdec_pkg::PH_TRAIL_SKIP;
        end
        cdec_pkg::PH_TRAIL_SKIP: begin
          if (byte_i == cdec_pkg::CH_CR) ctl_o.phase = cdec_pkg::PH_TRAIL_LF;
        end
        cdec_pkg::PH_TRAIL_LF: begin
          if (byte_i != cdec_pkg::CH_LF) begin
            st = cdec_pkg::ST_BAD;
          end else begin
            ctl_o.phase = cdec_pkg::PH_TRAIL;
          end
        end
        cdec_pkg::PH_END_LF: begin
          if (byte_i != cdec_pkg::CH_LF) begin
            st = cdec_pkg::ST_BAD;
          end else begin
            ctl_o.phase = cdec_pkg::PH_DONE;
            st          = cdec_pkg::ST_DONE;
          end
        end
        default: begin
          st = cdec_pkg::ST_BAD;
        end
      endcase
    end

    // Errors are sticky and suppress payload.
    if (st == cdec_pkg::ST_BAD) begin
      ctl_o     = cur;
      rem_o     = rem;
      ctl_o.err = 1'b1;
      pv        = 1'b0;
    end
  end

  assign res_o.payload_valid = pv;
  assign res_o.payload_byte  = pv ? byte_i : 8'd0;
  assign res_o.status        = st;

endmodule

// ===== rtl/cdec_checker.sv =====
// Port-level assertions for the chunked transfer decoder, bound to the top level.
// Depends on cdec_pkg for status codes.
module cdec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       payload_valid,
  input logic [7:0] payload_byte,
  input logic [1:0] status
);

  // No result word is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_valid)
      && $stable(payload_byte) && $stable(status))
    else $error("stalled result word changed");

  // An error or completion word never carries payload.
  a_bad_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == cdec_pkg::ST_BAD || status == cdec_pkg::ST_DONE)
      |-> !payload_valid && payload_byte == 8'd0)
    else $error("payload on an error or completion word");

  // A non-payload word has a zero byte and a known status.
  a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (payload_valid || payload_byte == 8'd0) && status != 2'd3)
    else $error("bad byte or status code on result word");

endmodule

bind chunked_transfer_decoder_core cdec_checker u_cdec_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_valid (out_ch.payload_valid),
  .payload_byte  (out_ch.payload_byte),
  .status        (out_ch.status)
);
